// ----- hdl/ifrs_pkg.sv -----
// ifrs_pkg: constants, command and status types for the int8 FIR filter.
// Used by ifrs_ctrl, ifrs_dp and int8_fir_round_saturate. No dependencies.
package ifrs_pkg;

  localparam int TAPS       = 32;                   // 1..32
  localparam int LINE_DEPTH = 32;
  localparam int LANES      = 4;                    // multipliers in the MAC unit
  localparam int NPASS      = LINE_DEPTH / LANES;
  localparam int PASS_W     = $clog2(NPASS);
  localparam int LANE_W     = $clog2(LANES);
  localparam int WIN_W      = LANES * 8;            // coefficient bits used per pass
  localparam int WIN_SH     = $clog2(WIN_W);
  localparam int FILL_W     = $clog2(TAPS + 1);
  localparam int ACC_W      = 32;
  localparam int PROD_W     = 16;

  localparam int SAMPLE_W   = 8;
  localparam int SHIFT_W    = 5;
  localparam int BANK_W     = 64;
  localparam int NBANKS     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_BANK_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BANK_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BANK_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BANK_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd4;

  localparam logic [SHIFT_W-1:0] SCALE_RESET = 5'd7;

  localparam logic signed [ACC_W-1:0] OUT_MAX = 32'sd127;
  localparam logic signed [ACC_W-1:0] OUT_MIN = -32'sd128;

  typedef struct packed {
    logic              load;  // take the item: shift sample in, seed accumulator
    logic              mac;   // one multiply-accumulate pass
    logic              fin;   // scale, saturate, write output register
    logic [PASS_W-1:0] pass;
  } cmd_t;

  typedef struct packed {
    logic emit;               // the item on the input port gives a result
  } stat_t;

endpackage

// ----- hdl/ifrs_ctrl.sv -----
// ifrs_ctrl: sequencer for the FIR filter (accept, MAC passes, finish).
// Depends on ifrs_pkg; drives ifrs_dp by cmd_t and owns the output valid.
module ifrs_ctrl import ifrs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAC  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(NPASS - 1);

  logic [1:0]        state_r, state_nxt;
  logic [PASS_W-1:0] pass_r, pass_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.load      = 1'b0;
    cmd.mac       = 1'b0;
    cmd.fin       = 1'b0;
    cmd.pass      = pass_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          pass_nxt = '0;
          if (stat.emit) begin
            state_nxt = S_MAC;
          end
        end
      end
      S_MAC: begin
        cmd.mac  = 1'b1;
        pass_nxt = pass_r + 1'b1;
        if (pass_r == LAST_PASS) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // wait here while the previous result is still held
        if (!out_valid_r || !out_stall) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hdl/ifrs_dp.sv -----
// ifrs_dp: FIR datapath - coefficient and scale registers, rotating delay
// line, fill count, four-lane MAC, round/shift/saturate. Depends on ifrs_pkg.
module ifrs_dp import ifrs_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cmd_t                         cmd,
  output stat_t                        stat,
  input  logic signed [SAMPLE_W-1:0]   in_sample,
  input  logic                         in_restart,
  input  logic                         cfg_wr,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  output logic signed [SAMPLE_W-1:0]   out_filtered
);

  logic [BANK_W-1:0]          bank_r [NBANKS];
  logic [SHIFT_W-1:0]         scale_r;
  logic [SAMPLE_W-1:0]        line_r [LINE_DEPTH];
  logic [FILL_W-1:0]          fill_r, fill_nxt, fill_base;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [SAMPLE_W-1:0] out_filtered_r, sat_val;

  logic [NBANKS*BANK_W-1:0]   coeff_flat;
  logic [WIN_W-1:0]           coeff_win;
  logic signed [ACC_W-1:0]    pass_sum, half, shifted;
  logic signed [PROD_W-1:0]   prod [LANES];
  logic [PASS_W+LANE_W-1:0]   tap_idx [LANES];

  assign coeff_flat = {bank_r[3], bank_r[2], bank_r[1], bank_r[0]};
  assign coeff_win  = coeff_flat[{cmd.pass, WIN_SH'(0)} +: WIN_W];

  // fill count: restart clears it before the new sample counts
  always_comb begin
    fill_base = in_restart ? '0 : fill_r;
    fill_nxt  = (int'(fill_base) < TAPS) ? fill_base + 1'b1 : fill_base;
    stat.emit = (int'(fill_nxt) >= TAPS);
  end

  // line_r[0..LANES-1] holds taps pass*LANES.. of the current pass
  always_comb begin
    pass_sum = '0;
    for (int l = 0; l < LANES; l++) begin
      tap_idx[l] = {cmd.pass, LANE_W'(l)};
      prod[l]    = $signed(coeff_win[l*8 +: 8]) * $signed(line_r[l]);
      if (int'(tap_idx[l]) < TAPS) begin
        pass_sum = pass_sum + ACC_W'(prod[l]);
      end
    end
  end

  assign half    = (scale_r == '0) ? '0 : (ACC_W'(1) <<< (scale_r - 1'b1));
  assign acc_nxt = acc_r + pass_sum;
  assign shifted = acc_r >>> scale_r;

  always_comb begin
    if (shifted > OUT_MAX) begin
      sat_val = SAMPLE_W'(OUT_MAX);
    end else if (shifted < OUT_MIN) begin
      sat_val = SAMPLE_W'(OUT_MIN);
    end else begin
      sat_val = shifted[SAMPLE_W-1:0];
    end
  end

  assign out_filtered = out_filtered_r;

  // configuration and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NBANKS; b++) begin
        bank_r[b] <= '0;
      end
      scale_r <= SCALE_RESET;
      fill_r  <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_BANK_0: bank_r[0] <= cfg_data;
          REG_BANK_1: bank_r[1] <= cfg_data;
          REG_BANK_2: bank_r[2] <= cfg_data;
          REG_BANK_3: bank_r[3] <= cfg_data;
          REG_SCALE:  scale_r   <= cfg_data[SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        fill_r <= fill_nxt;
      end
    end
  end

  // delay line: shift on load, rotate by LANES per pass (back in place after
  // NPASS passes); accumulator seeded with the rounding term
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      line_r[0] <= in_sample;
      for (int k = 1; k < LINE_DEPTH; k++) begin
        line_r[k] <= line_r[k-1];
      end
      acc_r <= half;
    end else if (cmd.mac) begin
      for (int k = 0; k < LINE_DEPTH; k++) begin
        line_r[k] <= line_r[(k + LANES) % LINE_DEPTH];
      end
      acc_r <= acc_nxt;
    end
    if (cmd.fin) begin
      out_filtered_r <= sat_val;
    end
  end

endmodule

// ----- hdl/int8_fir_round_saturate.sv -----
// int8_fir_round_saturate: 32-tap signed 8-bit FIR, round, scale, saturate.
// An item with a result runs accept, 8 four-lane MAC passes, then scale and
// saturate, which waits while the previous result is still stalled; out_valid
// rises after that step. An item still filling the line only shifts in.
// rst_n (synchronous, active low) clears fill count, coefficients (to 0) and
// scale shift (to 7). Depends on ifrs_pkg, ifrs_ctrl, ifrs_dp.
module int8_fir_round_saturate import ifrs_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  input  logic                        in_restart,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [SAMPLE_W-1:0]  out_filtered,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  ifrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ifrs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_sample    (in_sample),
    .in_restart   (in_restart),
    .cfg_wr       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_filtered (out_filtered)
  );

endmodule
